>>> rtl/htq_pkg.sv
// Shared constants, types and codes for the heightfield triangle height query core.
// No dependencies; used by every module in rtl/.
`default_nettype none

package htq_pkg;

    localparam int GRID_POINTS = 32;
    localparam int IDX_W       = $clog2(GRID_POINTS);
    localparam int ADDR_W      = $clog2(GRID_POINTS * GRID_POINTS);

    localparam int VTX_W    = 5;
    localparam int HGT_W    = 16;
    localparam int CRD_W    = 21;
    localparam int CS_W     = 8;
    localparam int CI_W     = 5;
    localparam int GX_W     = CRD_W + 2;
    localparam int D_W      = CS_W + 8;
    localparam int OFF_PW   = CS_W + CI_W;
    localparam int MUL_W    = D_W + 1;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 36;
    localparam int RES_W    = HGT_W;
    localparam int CNT_W    = 4;
    localparam int READ_LAST = 4;
    localparam int MUL_LAST  = 3;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_INDEX = 1'd1;

    localparam logic [CS_W-1:0] CS_RESET = 8'd5;
    localparam logic [CI_W-1:0] CI_RESET = 5'd10;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [RES_W-1:0] SAT_MAX = 16'h7FFF;
    localparam logic [RES_W-1:0] SAT_MIN = 16'h8000;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_OFF  = 11'b00000000010,
        ST_GRID = 11'b00000000100,
        ST_DIVX = 11'b00000001000,
        ST_DIVZ = 11'b00000010000,
        ST_CHK  = 11'b00000100000,
        ST_READ = 11'b00001000000,
        ST_MUL  = 11'b00010000000,
        ST_SIGN = 11'b00100000000,
        ST_DIVR = 11'b01000000000,
        ST_FIN  = 11'b10000000000
    } state_t;

    typedef struct packed {
        state_t             state;
        logic [CNT_W-1:0]   cnt;
    } ctl_t;

    typedef struct packed {
        logic start;
        logic early_oor;
        logic range_oor;
        logic acc_neg;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/htq_trial_sub.sv
// Shared trial-subtract unit: compares a partial remainder against a shifted divisor.
// Depends on htq_pkg.
`default_nettype none

module htq_trial_sub (
    input  wire logic [htq_pkg::ACC_W-1:0] rem,
    input  wire logic [htq_pkg::ACC_W-1:0] divisor,
    output logic                           ge,
    output logic [htq_pkg::ACC_W-1:0]      diff
);

    logic [htq_pkg::ACC_W:0] sub;

    assign sub  = {1'b0, rem} - {1'b0, divisor};
    assign ge   = ~sub[htq_pkg::ACC_W];
    assign diff = sub[htq_pkg::ACC_W-1:0];

endmodule

`default_nettype wire

>>> rtl/htq_ctrl.sv
// Sequencer for one query: offset, two cell divisions, corner reads, products,
// final rounding division. Depends on htq_pkg.
`default_nettype none

module htq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire htq_pkg::sts_t sts,
    output htq_pkg::ctl_t      ctl
);

    htq_pkg::state_t               state_reg;
    htq_pkg::state_t               state_next;
    logic [htq_pkg::CNT_W-1:0]     cnt_reg;
    logic [htq_pkg::CNT_W-1:0]     cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            htq_pkg::ST_IDLE:
            begin
                if (sts.start)
                begin
                    state_next = htq_pkg::ST_OFF;
                end
            end
            htq_pkg::ST_OFF:
            begin
                state_next = htq_pkg::ST_GRID;
            end
            htq_pkg::ST_GRID:
            begin
                if (sts.early_oor)
                begin
                    state_next = htq_pkg::ST_FIN;
                end
                else
                begin
                    state_next = htq_pkg::ST_DIVX;
                    cnt_next   = htq_pkg::CNT_W'(htq_pkg::IDX_W - 1);
                end
            end
            htq_pkg::ST_DIVX:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = htq_pkg::ST_DIVZ;
                    cnt_next   = htq_pkg::CNT_W'(htq_pkg::IDX_W - 1);
                end
                else
                begin
                    cnt_next = cnt_reg - htq_pkg::CNT_W'(1);
                end
            end
            htq_pkg::ST_DIVZ:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = htq_pkg::ST_CHK;
                end
                else
                begin
                    cnt_next = cnt_reg - htq_pkg::CNT_W'(1);
                end
            end
            htq_pkg::ST_CHK:
            begin
                if (sts.range_oor)
                begin
                    state_next = htq_pkg::ST_FIN;
                end
                else
                begin
                    state_next = htq_pkg::ST_READ;
                    cnt_next   = '0;
                end
            end
            htq_pkg::ST_READ:
            begin
                if (cnt_reg == htq_pkg::CNT_W'(htq_pkg::READ_LAST))
                begin
                    state_next = htq_pkg::ST_MUL;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + htq_pkg::CNT_W'(1);
                end
            end
            htq_pkg::ST_MUL:
            begin
                if (cnt_reg == htq_pkg::CNT_W'(htq_pkg::MUL_LAST))
                begin
                    state_next = htq_pkg::ST_SIGN;
                end
                else
                begin
                    cnt_next = cnt_reg + htq_pkg::CNT_W'(1);
                end
            end
            htq_pkg::ST_SIGN:
            begin
                if (sts.acc_neg)
                begin
                    state_next = htq_pkg::ST_FIN;
                end
                else
                begin
                    state_next = htq_pkg::ST_DIVR;
                    cnt_next   = htq_pkg::CNT_W'(htq_pkg::RES_W - 1);
                end
            end
            htq_pkg::ST_DIVR:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = htq_pkg::ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - htq_pkg::CNT_W'(1);
                end
            end
            htq_pkg::ST_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = htq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = htq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= htq_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign ctl.state = state_reg;
    assign ctl.cnt   = cnt_reg;

endmodule

`default_nettype wire

>>> rtl/heightfield_triangle_height_query_core.sv
// Top level: height table memory, datapath registers and output register.
// Depends on htq_pkg, htq_trial_sub and htq_ctrl.
//
// Usage: input items arrive on in_valid/in_stall. operation = write stores
// height_in at (vertex_col, vertex_row) and makes no result. operation = query
// returns one item on out_valid/out_stall: the height of the triangle under
// (query_x, query_z), or 0 with out_of_range set.
// A query holds in_stall high from its transfer until its result is loaded
// into the output register. Points left of or behind the grid or with zero
// cell size finish after the grid mapping, points beyond it after the divisions.
// The stall time is set by the single trial-subtract unit, which runs both cell
// divisions (one quotient bit per cycle) and the 16-bit rounding division,
// plus four reads through the table's single read port and four passes through
// one 17x17 multiplier (origin offset, then three products). A pending result
// waits in the output register while out_stall is high; the sequencer holds
// in its final state until it is free.
// Configuration (cfg_index/cfg_data) is always ready and takes effect at once;
// write it only while idle. Reset loads cell_size 5 and center_index 10,
// clears the sequencer and output valid; the table contents stay undefined.
`default_nettype none

module heightfield_triangle_height_query_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [htq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [htq_pkg::CS_W-1:0]          cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              operation,
    input  wire logic [htq_pkg::VTX_W-1:0]         vertex_col,
    input  wire logic [htq_pkg::VTX_W-1:0]         vertex_row,
    input  wire logic signed [htq_pkg::HGT_W-1:0]  height_in,
    input  wire logic signed [htq_pkg::CRD_W-1:0]  query_x,
    input  wire logic signed [htq_pkg::CRD_W-1:0]  query_z,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [htq_pkg::HGT_W-1:0]       height_out,
    output logic                                   out_of_range
);

    htq_pkg::ctl_t  ctl;
    htq_pkg::sts_t  sts;

    logic [htq_pkg::CS_W-1:0]             cs_reg;
    logic [htq_pkg::CI_W-1:0]             ci_reg;

    logic signed [htq_pkg::CRD_W-1:0]     x_reg;
    logic signed [htq_pkg::CRD_W-1:0]     z_reg;
    logic [htq_pkg::GX_W-1:0]             rem_x_reg;
    logic [htq_pkg::GX_W-1:0]             rem_z_reg;
    logic [htq_pkg::IDX_W-1:0]            qx_reg;
    logic [htq_pkg::IDX_W-1:0]            qz_reg;
    logic [htq_pkg::RES_W-1:0]            q_reg;
    logic [htq_pkg::ACC_W-1:0]            div_reg;
    logic signed [htq_pkg::ACC_W-1:0]     acc_reg;
    logic signed [htq_pkg::PROD_W-1:0]    prod_reg;
    logic signed [htq_pkg::HGT_W-1:0]     h0_reg;
    logic signed [htq_pkg::HGT_W-1:0]     h1_reg;
    logic signed [htq_pkg::HGT_W-1:0]     h2_reg;
    logic signed [htq_pkg::HGT_W-1:0]     h3_reg;
    logic signed [htq_pkg::HGT_W-1:0]     rd_reg;
    logic                                 oor_reg;
    logic                                 neg_reg;

    logic                                 out_valid_reg;
    logic [htq_pkg::RES_W-1:0]            height_reg;
    logic                                 oor_out_reg;

    logic [htq_pkg::HGT_W-1:0] mem [htq_pkg::GRID_POINTS * htq_pkg::GRID_POINTS];

    logic                                 in_xfer;
    logic                                 we;
    logic [htq_pkg::ADDR_W-1:0]           waddr;
    logic [htq_pkg::ADDR_W-1:0]           raddr;
    logic [htq_pkg::IDX_W-1:0]            rd_col;
    logic [htq_pkg::IDX_W-1:0]            rd_row;

    logic [htq_pkg::D_W-1:0]              d;
    logic signed [htq_pkg::GX_W-1:0]      x_ext;
    logic signed [htq_pkg::GX_W-1:0]      z_ext;
    logic signed [htq_pkg::GX_W-1:0]      off_ext;
    logic signed [htq_pkg::GX_W-1:0]      gx;
    logic signed [htq_pkg::GX_W-1:0]      gz;

    logic [htq_pkg::D_W-1:0]              rx;
    logic [htq_pkg::D_W-1:0]              rz;
    logic                                 lo_tri;
    logic [htq_pkg::D_W-1:0]              w1;
    logic [htq_pkg::D_W-1:0]              w2;
    logic signed [htq_pkg::MUL_W-1:0]     diff1;
    logic signed [htq_pkg::MUL_W-1:0]     diff2;
    logic signed [htq_pkg::HGT_W-1:0]     base;
    logic signed [htq_pkg::MUL_W-1:0]     mul_a;
    logic signed [htq_pkg::MUL_W-1:0]     mul_b;
    logic [htq_pkg::ACC_W-1:0]            acc_init;

    logic [htq_pkg::ACC_W-1:0]            trial_rem;
    logic                                 trial_ge;
    logic [htq_pkg::ACC_W-1:0]            trial_diff;

    logic                                 ovf;
    logic [htq_pkg::RES_W-1:0]            res;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg <= htq_pkg::CS_RESET;
            ci_reg <= htq_pkg::CI_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                htq_pkg::REG_CELL_SIZE:    cs_reg <= cfg_data;
                htq_pkg::REG_CENTER_INDEX: ci_reg <= cfg_data[htq_pkg::CI_W-1:0];
                default:                   ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    htq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    assign in_stall = (ctl.state != htq_pkg::ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    // ---------------- grid mapping ----------------
    assign d       = {cs_reg, 8'b0};
    assign x_ext   = htq_pkg::GX_W'(x_reg);
    assign z_ext   = htq_pkg::GX_W'(z_reg);
    assign off_ext = htq_pkg::GX_W'({prod_reg[htq_pkg::OFF_PW-1:0], 8'b0});
    assign gx      = x_ext + off_ext;
    assign gz      = off_ext - z_ext;

    assign rx      = rem_x_reg[htq_pkg::D_W-1:0];
    assign rz      = rem_z_reg[htq_pkg::D_W-1:0];

    assign sts.start     = in_xfer && (operation == htq_pkg::OP_QUERY);
    assign sts.early_oor = (cs_reg == '0) || gx[htq_pkg::GX_W-1] || gz[htq_pkg::GX_W-1];
    assign sts.range_oor = (rem_x_reg >= htq_pkg::GX_W'(d))
                        || (rem_z_reg >= htq_pkg::GX_W'(d))
                        || (qx_reg > htq_pkg::IDX_W'(htq_pkg::GRID_POINTS - 2))
                        || (qz_reg > htq_pkg::IDX_W'(htq_pkg::GRID_POINTS - 2));
    assign sts.acc_neg   = acc_reg[htq_pkg::ACC_W-1];
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // ---------------- height table ----------------
    assign we     = in_xfer && (operation == htq_pkg::OP_WRITE)
                 && (int'(vertex_col) < htq_pkg::GRID_POINTS)
                 && (int'(vertex_row) < htq_pkg::GRID_POINTS);
    assign waddr  = htq_pkg::ADDR_W'(vertex_row) * htq_pkg::ADDR_W'(htq_pkg::GRID_POINTS)
                  + htq_pkg::ADDR_W'(vertex_col);
    assign rd_col = qx_reg + htq_pkg::IDX_W'(ctl.cnt[0]);
    assign rd_row = qz_reg + htq_pkg::IDX_W'(ctl.cnt[1]);
    assign raddr  = htq_pkg::ADDR_W'(rd_row) * htq_pkg::ADDR_W'(htq_pkg::GRID_POINTS)
                  + htq_pkg::ADDR_W'(rd_col);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= height_in;
        end
        rd_reg <= mem[raddr];
    end

    // ---------------- multiplier operands ----------------
    assign lo_tri = ({1'b0, rx} + {1'b0, rz}) < {1'b0, d};
    assign w1     = lo_tri ? rx : d - rx;
    assign w2     = lo_tri ? rz : d - rz;
    assign base   = lo_tri ? h0_reg : h3_reg;
    assign diff1  = lo_tri ? htq_pkg::MUL_W'(h1_reg) - htq_pkg::MUL_W'(h0_reg)
                           : htq_pkg::MUL_W'(h2_reg) - htq_pkg::MUL_W'(h3_reg);
    assign diff2  = lo_tri ? htq_pkg::MUL_W'(h2_reg) - htq_pkg::MUL_W'(h0_reg)
                           : htq_pkg::MUL_W'(h1_reg) - htq_pkg::MUL_W'(h3_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (ctl.state == htq_pkg::ST_OFF)
        begin
            mul_a = htq_pkg::MUL_W'(ci_reg);
            mul_b = htq_pkg::MUL_W'(cs_reg);
        end
        else if (ctl.state == htq_pkg::ST_MUL)
        begin
            case (ctl.cnt)
                htq_pkg::CNT_W'(0):
                begin
                    mul_a = htq_pkg::MUL_W'(base);
                    mul_b = signed'({1'b0, d});
                end
                htq_pkg::CNT_W'(1):
                begin
                    mul_a = signed'({1'b0, w1});
                    mul_b = diff1;
                end
                default:
                begin
                    mul_a = signed'({1'b0, w2});
                    mul_b = diff2;
                end
            endcase
        end
    end

    // bias so the rounding division sees a non-negative numerator: +d/2 and +32768*d
    assign acc_init = (htq_pkg::ACC_W'(d) << (htq_pkg::RES_W - 1))
                    + (htq_pkg::ACC_W'(cs_reg) << 7);

    // ---------------- shared trial-subtract unit ----------------
    always_comb
    begin
        case (ctl.state)
            htq_pkg::ST_DIVX: trial_rem = htq_pkg::ACC_W'(rem_x_reg);
            htq_pkg::ST_DIVZ: trial_rem = htq_pkg::ACC_W'(rem_z_reg);
            default:          trial_rem = $unsigned(acc_reg);
        endcase
    end

    htq_trial_sub u_trial (
        .rem     (trial_rem),
        .divisor (div_reg),
        .ge      (trial_ge),
        .diff    (trial_diff)
    );

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (ctl.state)
            htq_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    x_reg   <= query_x;
                    z_reg   <= query_z;
                    oor_reg <= 1'b0;
                    neg_reg <= 1'b0;
                end
            end
            htq_pkg::ST_GRID:
            begin
                rem_x_reg <= $unsigned(gx);
                rem_z_reg <= $unsigned(gz);
                oor_reg   <= sts.early_oor;
                div_reg   <= htq_pkg::ACC_W'(d) << (htq_pkg::IDX_W - 1);
            end
            htq_pkg::ST_DIVX:
            begin
                if (trial_ge)
                begin
                    rem_x_reg <= trial_diff[htq_pkg::GX_W-1:0];
                end
                qx_reg <= htq_pkg::IDX_W'({qx_reg, trial_ge});
                if (ctl.cnt == '0)
                begin
                    div_reg <= htq_pkg::ACC_W'(d) << (htq_pkg::IDX_W - 1);
                end
                else
                begin
                    div_reg <= div_reg >> 1;
                end
            end
            htq_pkg::ST_DIVZ:
            begin
                if (trial_ge)
                begin
                    rem_z_reg <= trial_diff[htq_pkg::GX_W-1:0];
                end
                qz_reg  <= htq_pkg::IDX_W'({qz_reg, trial_ge});
                div_reg <= div_reg >> 1;
            end
            htq_pkg::ST_CHK:
            begin
                oor_reg <= sts.range_oor;
                acc_reg <= signed'(acc_init);
            end
            htq_pkg::ST_READ:
            begin
                case (ctl.cnt)
                    htq_pkg::CNT_W'(1): h0_reg <= rd_reg;
                    htq_pkg::CNT_W'(2): h1_reg <= rd_reg;
                    htq_pkg::CNT_W'(3): h2_reg <= rd_reg;
                    htq_pkg::CNT_W'(4): h3_reg <= rd_reg;
                    default:            ;
                endcase
            end
            htq_pkg::ST_MUL:
            begin
                if (ctl.cnt != '0)
                begin
                    acc_reg <= acc_reg + htq_pkg::ACC_W'(prod_reg);
                end
            end
            htq_pkg::ST_SIGN:
            begin
                neg_reg <= acc_reg[htq_pkg::ACC_W-1];
                div_reg <= htq_pkg::ACC_W'(d) << (htq_pkg::RES_W - 1);
            end
            htq_pkg::ST_DIVR:
            begin
                if (trial_ge)
                begin
                    acc_reg <= signed'(trial_diff);
                end
                q_reg   <= {q_reg[htq_pkg::RES_W-2:0], trial_ge};
                div_reg <= div_reg >> 1;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- result and output register ----------------
    assign ovf = $unsigned(acc_reg) >= htq_pkg::ACC_W'(d);

    always_comb
    begin
        if (oor_reg)
        begin
            res = '0;
        end
        else if (neg_reg)
        begin
            res = htq_pkg::SAT_MIN;
        end
        else if (ovf)
        begin
            res = htq_pkg::SAT_MAX;
        end
        else
        begin
            res = {~q_reg[htq_pkg::RES_W-1], q_reg[htq_pkg::RES_W-2:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((ctl.state == htq_pkg::ST_FIN) && sts.out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((ctl.state == htq_pkg::ST_FIN) && sts.out_free)
        begin
            height_reg  <= res;
            oor_out_reg <= oor_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign height_out   = signed'(height_reg);
    assign out_of_range = oor_out_reg;

    // ---------------- assertions ----------------
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctl.state == htq_pkg::ST_FIN))
        else $error("result valid without finishing a query");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && oor_out_reg) |-> (height_reg == '0))
        else $error("out-of-range result with nonzero height");

    a_sign_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.state == htq_pkg::ST_SIGN) |-> !oor_reg)
        else $error("interpolation reached for a point outside the grid");

endmodule

`default_nettype wire

>>> verif/heightfield_triangle_height_query_core_tb.sv
// Self-checking testbench for heightfield_triangle_height_query_core: vertex writes and
// height queries under random idling, checked against an in-bench triangle interpolator.
// Depends on htq_pkg and the core RTL only.
`default_nettype none

module heightfield_triangle_height_query_core_tb;

    localparam int LAST_CELL     = htq_pkg::GRID_POINTS - 2;
    localparam int SETTLE_CYCLES = 50;
    localparam int IDLE_PCT      = 28;

    typedef struct {
        logic                             op;
        logic [htq_pkg::VTX_W-1:0]        col;
        logic [htq_pkg::VTX_W-1:0]        row;
        logic signed [htq_pkg::HGT_W-1:0] hgt;
        logic signed [htq_pkg::CRD_W-1:0] qx;
        logic signed [htq_pkg::CRD_W-1:0] qz;
    } probe_t;

    typedef struct {
        logic [htq_pkg::CFG_IDX_W-1:0] idx;
        logic [htq_pkg::CS_W-1:0]      data;
    } reg_write_t;

    typedef struct {
        logic signed [htq_pkg::HGT_W-1:0] height;
        logic                             oor;
    } height_exp_t;

    logic                              clk        = 1'b0;
    logic                              rst_n      = 1'b0;
    logic                              cfg_valid  = 1'b0;
    logic [htq_pkg::CFG_IDX_W-1:0]     cfg_index  = '0;
    logic [htq_pkg::CS_W-1:0]          cfg_data   = '0;
    logic                              in_valid   = 1'b0;
    logic                              operation  = htq_pkg::OP_WRITE;
    logic [htq_pkg::VTX_W-1:0]         vertex_col = '0;
    logic [htq_pkg::VTX_W-1:0]         vertex_row = '0;
    logic signed [htq_pkg::HGT_W-1:0]  height_in  = '0;
    logic signed [htq_pkg::CRD_W-1:0]  query_x    = '0;
    logic signed [htq_pkg::CRD_W-1:0]  query_z    = '0;
    logic                              out_stall  = 1'b0;
    logic                              cfg_ready;
    logic                              in_stall;
    logic                              out_valid;
    logic signed [htq_pkg::HGT_W-1:0]  height_out;
    logic                              out_of_range;

    probe_t      probe_q[$];
    reg_write_t  reg_q[$];
    height_exp_t height_exp_q[$];

    // predictor state
    logic signed [htq_pkg::HGT_W-1:0] vertex_height [htq_pkg::GRID_POINTS][htq_pkg::GRID_POINTS];
    int cur_cell_size = int'(htq_pkg::CS_RESET);
    int cur_center    = int'(htq_pkg::CI_RESET);

    // stimulus-side view
    bit vtx_loaded [htq_pkg::GRID_POINTS][htq_pkg::GRID_POINTS];
    int plan_cs = int'(htq_pkg::CS_RESET);
    int plan_ci = int'(htq_pkg::CI_RESET);
    bit steady  = 1'b0;

    int n_queued   = 0;
    int n_writes   = 0;
    int n_results  = 0;
    int n_outside  = 0;
    int n_settings = 1;
    int n_errors   = 0;

    heightfield_triangle_height_query_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .vertex_col   (vertex_col),
        .vertex_row   (vertex_row),
        .height_in    (height_in),
        .query_x      (query_x),
        .query_z      (query_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .height_out   (height_out),
        .out_of_range (out_of_range)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic log_mismatch(input string msg);
        n_errors++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Maps a world point to its cell and remainders; 0 when off the grid.
    function automatic bit find_cell(input longint x, input longint z, input int cs,
                                     input int ci, output longint i, output longint j,
                                     output longint rx, output longint rz);
        longint d, off, gx, gz;
        d   = 256 * longint'(cs);
        off = d * longint'(ci);
        gx  = x + off;
        gz  = -z + off;
        i = 0;
        j = 0;
        rx = 0;
        rz = 0;
        if (cs == 0 || gx < 0 || gz < 0)
            return 1'b0;
        i = gx / d;
        j = gz / d;
        if (i > LAST_CELL || j > LAST_CELL)
            return 1'b0;
        rx = gx - i * d;
        rz = gz - j * d;
        return 1'b1;
    endfunction

    function automatic void ground_height(input longint x, input longint z,
                                          output logic signed [htq_pkg::HGT_W-1:0] h,
                                          output logic oor);
        longint i, j, rx, rz, d, h0, h1, h2, h3, num, a, b, q;
        h   = '0;
        oor = 1'b1;
        if (!find_cell(x, z, cur_cell_size, cur_center, i, j, rx, rz))
            return;
        d  = 256 * longint'(cur_cell_size);
        h0 = vertex_height[j][i];
        h1 = vertex_height[j][i+1];
        h2 = vertex_height[j+1][i];
        h3 = vertex_height[j+1][i+1];
        if (rx + rz < d)
            num = h0 * d + rx * (h1 - h0) + rz * (h2 - h0);
        else
            num = h3 * d + (d - rx) * (h2 - h3) + (d - rz) * (h1 - h3);
        // round half up: floor((2*num + d) / (2*d))
        a = 2 * num + d;
        b = 2 * d;
        q = a / b;
        if (a % b != 0 && a < 0)
            q = q - 1;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        h   = q[htq_pkg::HGT_W-1:0];
        oor = 1'b0;
    endfunction

    // config channel
    always @(posedge clk or negedge rst_n)
    begin : drive_regs
        reg_write_t w;
        if (!rst_n)
        begin
            cfg_valid     <= 1'b0;
            cur_cell_size = int'(htq_pkg::CS_RESET);
            cur_center    = int'(htq_pkg::CI_RESET);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == htq_pkg::REG_CELL_SIZE)
                    cur_cell_size = int'(cfg_data);
                else if (cfg_index == htq_pkg::REG_CENTER_INDEX)
                    cur_center = int'(cfg_data[htq_pkg::CI_W-1:0]);
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_q.size() != 0)
                begin
                    w = reg_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.idx;
                    cfg_data  <= w.data;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // input driver; prediction happens on each accepted transfer
    always @(posedge clk or negedge rst_n)
    begin : drive_probes
        probe_t      nxt;
        height_exp_t eh;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (operation == htq_pkg::OP_WRITE)
                begin
                    vertex_height[vertex_row][vertex_col] = height_in;
                    n_writes++;
                end
                else
                begin
                    ground_height(query_x, query_z, eh.height, eh.oor);
                    height_exp_q.push_back(eh);
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (probe_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = probe_q.pop_front();
                    in_valid   <= 1'b1;
                    operation  <= nxt.op;
                    vertex_col <= nxt.col;
                    vertex_row <= nxt.row;
                    height_in  <= nxt.hgt;
                    query_x    <= nxt.qx;
                    query_z    <= nxt.qz;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : check_heights
        height_exp_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (height_exp_q.size() == 0)
                    log_mismatch($sformatf("result with none pending: height %0d oor %0b",
                                           height_out, out_of_range));
                else
                begin
                    want = height_exp_q.pop_front();
                    n_results++;
                    if (want.oor)
                        n_outside++;
                    if (height_out !== want.height)
                        log_mismatch($sformatf("height_out %0d, wanted %0d",
                                               height_out, want.height));
                    if (out_of_range !== want.oor)
                        log_mismatch($sformatf("out_of_range %0b, wanted %0b",
                                               out_of_range, want.oor));
                end
            end
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic add_write(input int col, input int row,
                             input logic signed [htq_pkg::HGT_W-1:0] h);
        probe_t p;
        p.op  = htq_pkg::OP_WRITE;
        p.col = htq_pkg::VTX_W'(col);
        p.row = htq_pkg::VTX_W'(row);
        p.hgt = h;
        p.qx  = htq_pkg::CRD_W'($urandom);
        p.qz  = htq_pkg::CRD_W'($urandom);
        vtx_loaded[row][col] = 1'b1;
        probe_q.push_back(p);
        n_queued++;
    endtask

    task automatic add_query(input longint x, input longint z);
        probe_t p;
        p.op  = htq_pkg::OP_QUERY;
        p.col = htq_pkg::VTX_W'($urandom);
        p.row = htq_pkg::VTX_W'($urandom);
        p.hgt = htq_pkg::HGT_W'($urandom);
        p.qx  = htq_pkg::CRD_W'(x);
        p.qz  = htq_pkg::CRD_W'(z);
        probe_q.push_back(p);
        n_queued++;
    endtask

    // World point for a cell and remainders under the planned setting; 0 if not encodable.
    function automatic bit place_point(input longint i, input longint j, input longint rx,
                                       input longint rz, output longint x, output longint z);
        longint d, off;
        d   = 256 * longint'(plan_cs);
        off = d * longint'(plan_ci);
        x = i * d + rx - off;
        z = off - (j * d + rz);
        return x >= -1048576 && x <= 1048575 && z >= -1048576 && z <= 1048575;
    endfunction

    task automatic add_at(input longint i, input longint j, input longint rx, input longint rz);
        longint x, z;
        if (place_point(i, j, rx, rz, x, z))
            add_query(x, z);
    endtask

    function automatic longint rand_offset(input longint d);
        case ($urandom_range(9))
            0: return 0;
            1: return d - 1;
            default: return $urandom_range(int'(d) - 1);
        endcase
    endfunction

    function automatic logic signed [htq_pkg::HGT_W-1:0] rand_height();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return htq_pkg::HGT_W'($urandom_range(511)) - 16'sd256;
            default: return htq_pkg::HGT_W'($urandom);
        endcase
    endfunction

    // Random point anywhere; kept only if it lands off the grid or on a loaded cell.
    task automatic add_noise_query();
        logic signed [htq_pkg::CRD_W-1:0] tx, tz;
        longint i, j, rx, rz;
        int tries;
        bit safe;
        safe = 1'b0;
        for (tries = 0; tries < 20 && !safe; tries++)
        begin
            tx = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 21'h100000 : 21'h0FFFFF)
                                          : htq_pkg::CRD_W'($urandom);
            tz = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 21'h100000 : 21'h0FFFFF)
                                          : htq_pkg::CRD_W'($urandom);
            safe = !find_cell(tx, tz, plan_cs, plan_ci, i, j, rx, rz) ||
                   (vtx_loaded[j][i] && vtx_loaded[j][i+1] &&
                    vtx_loaded[j+1][i] && vtx_loaded[j+1][i+1]);
        end
        if (safe)
            add_query(tx, tz);
        else
            add_write($urandom_range(31), $urandom_range(31), rand_height());
    endtask

    // Load the corners of a reachable cell, then query points inside it.
    task automatic add_cell_visit();
        longint d, i, j, rx, rz, x, z;
        int tries, k, nq;
        bit ok;
        d  = 256 * longint'(plan_cs);
        ok = 1'b0;
        if (d == 0)
        begin
            add_noise_query();
            return;
        end
        for (tries = 0; tries < 40 && !ok; tries++)
        begin
            i  = $urandom_range(LAST_CELL);
            j  = $urandom_range(LAST_CELL);
            rx = rand_offset(d);
            rz = ($urandom_range(4) == 0 && rx > 0) ? d - rx : rand_offset(d);
            ok = place_point(i, j, rx, rz, x, z);
        end
        if (!ok)
        begin
            add_noise_query();
            return;
        end
        for (k = 0; k < 4; k++)
        begin
            if (!vtx_loaded[j + k / 2][i + k % 2] || $urandom_range(3) == 0)
                add_write(int'(i + k % 2), int'(j + k / 2), rand_height());
        end
        add_query(x, z);
        nq = $urandom_range(2);
        repeat (nq)
        begin
            rx = rand_offset(d);
            rz = ($urandom_range(4) == 0 && rx > 0) ? d - rx : rand_offset(d);
            add_at(i, j, rx, rz);
        end
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (probe_q.size() != 0 || in_valid || height_exp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input int cs, input int ci, input int n, input bit calm);
        reg_write_t w;
        int first, r;
        settle();
        plan_cs = cs;
        plan_ci = ci;
        w.idx  = htq_pkg::REG_CELL_SIZE;
        w.data = htq_pkg::CS_W'(cs);
        reg_q.push_back(w);
        w.idx  = htq_pkg::REG_CENTER_INDEX;
        w.data = {3'($urandom), htq_pkg::CI_W'(ci)};
        reg_q.push_back(w);
        do
            @(negedge clk);
        while (reg_q.size() != 0 || cfg_valid);
        n_settings++;
        steady = calm;
        first  = n_queued;
        while (n_queued - first < n)
        begin
            r = $urandom_range(99);
            if (r < 60)
                add_cell_visit();
            else if (r < 82)
                add_noise_query();
            else
                add_write($urandom_range(31), $urandom_range(31), rand_height());
        end
    endtask

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset setting (cell 1280, origin 12800)
        add_write(0, 0, 16'sh8000);
        add_write(1, 0, 16'sh7FFF);
        add_write(0, 1, 16'sh0000);
        add_write(1, 1, -16'sd1);
        add_write(30, 30, 16'sd1234);
        add_write(31, 30, -16'sd700);
        add_write(30, 31, 16'sh7FFF);
        add_write(31, 31, 16'sh8000);
        add_at(0, 0, 0, 0);
        add_at(0, 0, 640, 640);
        add_at(0, 0, 1, 0);
        add_at(0, 0, 0, 1279);
        add_at(0, 0, 1279, 1279);
        add_at(30, 30, 0, 0);
        add_at(30, 30, 1279, 1279);
        add_at(30, 30, 700, 580);
        add_at(30, 30, 3, 1);
        add_query(-12801, 0);
        add_query(0, 12801);
        add_query(26880, 0);
        add_query(0, -26880);
        add_query(-1048576, 1048575);
        add_query(1048575, -1048576);

        run_phase(1, 0, 55, 1'b0);
        run_phase(255, 31, 55, 1'b1);
        run_phase(255, 0, 55, 1'b0);
        run_phase(1, 31, 55, 1'b0);
        run_phase(0, 10, 30, 1'b0);
        run_phase($urandom_range(1, 255), $urandom_range(31), 55, 1'b0);
        run_phase(128, 16, 55, 1'b0);
        run_phase($urandom_range(1, 16), $urandom_range(31), 60, 1'b0);
        settle();

        $display("Covered %0d vertex writes and %0d query results, %0d of them off the grid,",
                 n_writes, n_results, n_outside);
        $display("over %0d register settings including zero and both extreme cell sizes.",
                 n_settings);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
